// File: sv/ensc_pkg.sv
// shared types, constants and range tables for the environmental sensor compensation block
package ensc_pkg;

  localparam int TS_STG  = 5;
  localparam int TH_LAST = 21;
  localparam int GAS_PRE = 5;
  localparam int DIV_STG = 25;
  localparam int NSTG    = GAS_PRE + DIV_STG;
  localparam int NUM_W   = 2 * DIV_STG;
  localparam int DEN_W   = 27;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 40;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CURVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_COEFFS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAS_ERR    = 3'd6;

  localparam logic [31:0] RECIP100 = 32'h51EB851F;
  localparam logic [16:0] HUM_MAX  = 17'd100000;

  typedef struct packed {
    logic [19:0] adc_temp;
    logic [15:0] adc_hum;
    logic [9:0]  adc_gas;
    logic [3:0]  range_sel;
    logic        gas_flag;
    logic        heat_stable;
  } in_t;

  typedef struct packed {
    logic [16:0] temperature_centi;
    logic [16:0] humidity_milli;
    logic [31:0] gas_ohm;
    logic        gas_ok;
  } out_t;

  typedef struct packed {
    logic [15:0] temp_base;
    logic [15:0] temp_gain;
    logic [7:0]  temp_curve;
    logic [11:0] hum_offset;
    logic [11:0] hum_gain;
    logic [39:0] hum_coeffs;
    logic [3:0]  gas_switch_error;
  } cfg_t;

  // sign and magnitude of a 32-bit value
  function automatic logic [32:0] mag_split(logic signed [31:0] x);
    logic [31:0] m;
    m = x[31] ? 32'(-x) : 32'(x);
    return {x[31], m};
  endfunction

  // truncating quotient by 100 from the reciprocal product
  function automatic logic signed [31:0] div100_fin(logic neg, logic [63:0] prod);
    logic [31:0] q;
    q = {5'b0, prod[63:37]};
    return neg ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic [31:0] tab_a(logic [3:0] r);
    logic [31:0] v;
    case (r)
      4'd5:    v = 32'd2126008810;
      4'd7:    v = 32'd2130303777;
      4'd10:   v = 32'd2143188679;
      4'd11:   v = 32'd2136746228;
      4'd13:   v = 32'd2126008810;
      default: v = 32'd2147483647;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] tab_b(logic [3:0] r);
    logic [31:0] v;
    case (r)
      4'd0:    v = 32'd4096000000;
      4'd1:    v = 32'd2048000000;
      4'd2:    v = 32'd1024000000;
      4'd3:    v = 32'd512000000;
      4'd4:    v = 32'd255744255;
      4'd5:    v = 32'd127110228;
      4'd6:    v = 32'd64000000;
      4'd7:    v = 32'd32258064;
      4'd8:    v = 32'd16016016;
      4'd9:    v = 32'd8000000;
      4'd10:   v = 32'd4000000;
      4'd11:   v = 32'd2000000;
      4'd12:   v = 32'd1000000;
      4'd13:   v = 32'd500000;
      4'd14:   v = 32'd250000;
      default: v = 32'd125000;
    endcase
    return v;
  endfunction

endpackage

// File: sv/ensc_thpath.sv
// temperature and humidity compensation pipeline
module ensc_thpath (
  input  logic                        clk_i,
  input  logic [ensc_pkg::NSTG-1:0]   en_i,
  input  ensc_pkg::cfg_t              cfg_i,
  input  ensc_pkg::in_t               in_data_i,
  output logic [16:0]                 temp_o,
  output logic [16:0]                 hum_o
);

  localparam int CF_C3 = 0;
  localparam int CF_C4 = 1;
  localparam int CF_C5 = 2;
  localparam int CF_C7 = 3;
  localparam int TS_N  = ensc_pkg::NSTG - ensc_pkg::TS_STG;
  localparam int HD_N  = ensc_pkg::NSTG - ensc_pkg::TH_LAST;

  logic signed [7:0] coef [4];
  logic [7:0]        c6;

  assign coef[CF_C3] = $signed(cfg_i.hum_coeffs[7:0]);
  assign coef[CF_C4] = $signed(cfg_i.hum_coeffs[15:8]);
  assign coef[CF_C5] = $signed(cfg_i.hum_coeffs[23:16]);
  assign coef[CF_C7] = $signed(cfg_i.hum_coeffs[39:32]);
  assign c6          = cfg_i.hum_coeffs[31:24];

  // carried values, index is stage minus first stage
  logic [19:0]        adc_t_q;
  logic [15:0]        hum_q   [10];
  logic signed [16:0] ts_q    [TS_N];
  logic signed [31:0] ha_q    [6];
  logic signed [27:0] dv_q    [8];
  logic signed [31:0] q4_q    [4];
  logic signed [31:0] v3_q    [3];
  logic [16:0]        hd_q    [HD_N];

  logic signed [18:0] s1_a_q,    s1_a_d;
  logic signed [31:0] s2_pb_q,   s2_pb_d;
  logic signed [31:0] s2_sq_q,   s2_sq_d;
  logic signed [20:0] s3_b_q,    s3_b_d;
  logic signed [31:0] s3_pc_q,   s3_pc_d;
  logic signed [21:0] s4_fine_q, s4_fine_d;
  logic signed [16:0] s5_ts_d;
  logic signed [31:0] s6_pr_q  [4];
  logic signed [31:0] s6_pr_d  [4];
  logic               s7_neg_q [4];
  logic               s7_neg_d [4];
  logic [31:0]        s7_mag_q [4];
  logic [31:0]        s7_mag_d [4];
  logic               s8_neg_q [4];
  logic [63:0]        s8_pm_q  [4];
  logic [63:0]        s8_pm_d  [4];
  logic signed [31:0] s9_quo_q [4];
  logic signed [31:0] s9_quo_d [4];
  logic signed [31:0] s10_ptb_q, s10_ptb_d;
  logic signed [31:0] s10_ha_d;
  logic signed [27:0] s10_d_d;
  logic               s11_neg_q, s11_neg_d;
  logic [31:0]        s11_mag_q, s11_mag_d;
  logic               s12_neg_q;
  logic [63:0]        s12_pm_q,  s12_pm_d;
  logic signed [31:0] s13_q6_q,  s13_q6_d;
  logic signed [31:0] s14_b_q,   s14_b_d;
  logic signed [31:0] s15_pb_q,  s15_pb_d;
  logic signed [31:0] s16_v3_d;
  logic signed [31:0] s17_v5p_q, s17_v5p_d;
  logic signed [31:0] s18_v6p_q, s18_v6p_d;
  logic signed [31:0] s19_s_q,   s19_s_d;
  logic signed [31:0] s20_hp_q,  s20_hp_d;
  logic [16:0]        s21_h_d;

  always_comb begin
    logic signed [34:0] m35;
    logic signed [17:0] ah;
    logic signed [35:0] m36a;
    logic signed [24:0] t5;
    logic signed [24:0] m25 [4];
    logic [32:0]        sp  [4];
    logic [32:0]        sp1;
    logic signed [48:0] m49;
    logic signed [31:0] dsum;
    logic signed [31:0] x11;
    logic signed [44:0] m45;
    logic signed [53:0] m54;
    logic signed [17:0] qq;
    logic signed [35:0] m36;
    logic signed [49:0] m50;
    logic signed [32:0] m33;
    logic signed [19:0] hv;

    // temperature
    s1_a_d = $signed({2'b00, adc_t_q[19:3]}) - $signed({2'b00, cfg_i.temp_base, 1'b0});
    m35     = s1_a_q * $signed(cfg_i.temp_gain);
    s2_pb_d = m35[31:0];
    ah      = s1_a_q[18:1];
    m36a    = ah * ah;
    s2_sq_d = m36a[31:0];
    s3_b_d  = s2_pb_q[31:11];
    s3_pc_d = $signed(s2_sq_q[31:12]) * $signed({cfg_i.temp_curve, 4'b0000});
    s4_fine_d = s3_b_q + $signed(s3_pc_q[31:14]);
    t5      = (s4_fine_q <<< 2) + s4_fine_q + 25'sd128;
    s5_ts_d = t5[24:8];

    // humidity divisions by 100
    for (int i = 0; i < 4; i++) begin
      m25[i]      = coef[i] * ts_q[0];
      s6_pr_d[i]  = {{7{m25[i][24]}}, m25[i]};
      sp[i]       = ensc_pkg::mag_split(s6_pr_q[i]);
      s7_neg_d[i] = sp[i][32];
      s7_mag_d[i] = sp[i][31:0];
      s8_pm_d[i]  = 64'(s7_mag_q[i]) * 64'(ensc_pkg::RECIP100);
      s9_quo_d[i] = ensc_pkg::div100_fin(s8_neg_q[i], s8_pm_q[i]);
    end

    m49       = ts_q[4] * s9_quo_q[CF_C5];
    s10_ptb_d = m49[31:0];
    s10_ha_d  = $signed({16'b0, hum_q[9]}) - $signed({16'b0, cfg_i.hum_offset, 4'b0000})
                - (s9_quo_q[CF_C3] >>> 1);
    dsum      = $signed({17'b0, c6, 7'b0}) + s9_quo_q[CF_C7];
    s10_d_d   = dsum[31:4];

    x11       = {{6{s10_ptb_q[31]}}, s10_ptb_q[31:6]};
    sp1       = ensc_pkg::mag_split(x11);
    s11_neg_d = sp1[32];
    s11_mag_d = sp1[31:0];
    s12_pm_d  = 64'(s11_mag_q) * 64'(ensc_pkg::RECIP100);
    s13_q6_d  = ensc_pkg::div100_fin(s12_neg_q, s12_pm_q);
    s14_b_d   = q4_q[3] + s13_q6_q + 32'sd16384;

    m45       = $signed({1'b0, cfg_i.hum_gain}) * s14_b_q;
    s15_pb_d  = m45[31:0];
    m54       = ha_q[5] * $signed(s15_pb_q[31:10]);
    s16_v3_d  = m54[31:0];
    qq        = v3_q[0][31:14];
    m36       = qq * qq;
    s17_v5p_d = m36[31:0];
    m50       = dv_q[7] * $signed(s17_v5p_q[31:10]);
    s18_v6p_d = m50[31:0];
    s19_s_d   = v3_q[2] + (s18_v6p_q >>> 1);
    m33       = $signed(s19_s_q[31:10]) * 11'sd1000;
    s20_hp_d  = m33[31:0];

    hv = s20_hp_q[31:12];
    if (hv > $signed({3'b000, ensc_pkg::HUM_MAX})) begin
      s21_h_d = ensc_pkg::HUM_MAX;
    end else if (hv < 0) begin
      s21_h_d = '0;
    end else begin
      s21_h_d = hv[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      adc_t_q  <= in_data_i.adc_temp;
      hum_q[0] <= in_data_i.adc_hum;
    end
    for (int k = 1; k < 10; k++) begin
      if (en_i[k]) begin
        hum_q[k] <= hum_q[k-1];
      end
    end
    if (en_i[1]) begin
      s1_a_q <= s1_a_d;
    end
    if (en_i[2]) begin
      s2_pb_q <= s2_pb_d;
      s2_sq_q <= s2_sq_d;
    end
    if (en_i[3]) begin
      s3_b_q  <= s3_b_d;
      s3_pc_q <= s3_pc_d;
    end
    if (en_i[4]) begin
      s4_fine_q <= s4_fine_d;
    end
    if (en_i[ensc_pkg::TS_STG]) begin
      ts_q[0] <= s5_ts_d;
    end
    for (int k = 1; k < TS_N; k++) begin
      if (en_i[ensc_pkg::TS_STG+k]) begin
        ts_q[k] <= ts_q[k-1];
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (en_i[6]) begin
        s6_pr_q[i] <= s6_pr_d[i];
      end
      if (en_i[7]) begin
        s7_neg_q[i] <= s7_neg_d[i];
        s7_mag_q[i] <= s7_mag_d[i];
      end
      if (en_i[8]) begin
        s8_neg_q[i] <= s7_neg_q[i];
        s8_pm_q[i]  <= s8_pm_d[i];
      end
      if (en_i[9]) begin
        s9_quo_q[i] <= s9_quo_d[i];
      end
    end
    if (en_i[10]) begin
      s10_ptb_q <= s10_ptb_d;
      ha_q[0]   <= s10_ha_d;
      dv_q[0]   <= s10_d_d;
      q4_q[0]   <= s9_quo_q[CF_C4];
    end
    for (int k = 1; k < 6; k++) begin
      if (en_i[10+k]) begin
        ha_q[k] <= ha_q[k-1];
      end
    end
    for (int k = 1; k < 8; k++) begin
      if (en_i[10+k]) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (en_i[10+k]) begin
        q4_q[k] <= q4_q[k-1];
      end
    end
    if (en_i[11]) begin
      s11_neg_q <= s11_neg_d;
      s11_mag_q <= s11_mag_d;
    end
    if (en_i[12]) begin
      s12_neg_q <= s11_neg_q;
      s12_pm_q  <= s12_pm_d;
    end
    if (en_i[13]) begin
      s13_q6_q <= s13_q6_d;
    end
    if (en_i[14]) begin
      s14_b_q <= s14_b_d;
    end
    if (en_i[15]) begin
      s15_pb_q <= s15_pb_d;
    end
    if (en_i[16]) begin
      v3_q[0] <= s16_v3_d;
    end
    for (int k = 1; k < 3; k++) begin
      if (en_i[16+k]) begin
        v3_q[k] <= v3_q[k-1];
      end
    end
    if (en_i[17]) begin
      s17_v5p_q <= s17_v5p_d;
    end
    if (en_i[18]) begin
      s18_v6p_q <= s18_v6p_d;
    end
    if (en_i[19]) begin
      s19_s_q <= s19_s_d;
    end
    if (en_i[20]) begin
      s20_hp_q <= s20_hp_d;
    end
    if (en_i[ensc_pkg::TH_LAST]) begin
      hd_q[0] <= s21_h_d;
    end
    for (int k = 1; k < HD_N; k++) begin
      if (en_i[ensc_pkg::TH_LAST+k]) begin
        hd_q[k] <= hd_q[k-1];
      end
    end
  end

  assign temp_o = ts_q[TS_N-1];
  assign hum_o  = hd_q[HD_N-1];

endmodule

// File: sv/ensc_gaspath.sv
// gas resistance pipeline with a radix-4 restoring divider
module ensc_gaspath (
  input  logic                        clk_i,
  input  logic [ensc_pkg::NSTG-1:0]   en_i,
  input  ensc_pkg::cfg_t              cfg_i,
  input  ensc_pkg::in_t               in_data_i,
  output logic [31:0]                 gas_ohm_o,
  output logic                        gas_ok_o
);

  localparam int NW = ensc_pkg::NUM_W;
  localparam int DW = ensc_pkg::DEN_W;
  localparam int DS = ensc_pkg::DIV_STG;
  localparam int GP = ensc_pkg::GAS_PRE;

  logic [9:0]  s0_adc_q;
  logic [3:0]  s0_rng_q;
  logic        ok_q [GP-1];
  logic [41:0] s1_g1p_q, s1_g1p_d;
  logic [31:0] s1_tb_q;
  logic [9:0]  s1_adc_q;
  logic [25:0] s2_g1_q;
  logic [31:0] s2_tb_q;
  logic [9:0]  s2_adc_q;
  logic [57:0] s3_g3p_q, s3_g3p_d;
  logic signed [27:0] s3_g2_q, s3_g2_d;

  // divider stages, index 0 is the operand stage
  logic [NW-1:0] num_q [DS+1];
  logic [DW-1:0] den_q [DS+1];
  logic [DW-1:0] rem_q [DS+1];
  logic [31:0]   quo_q [DS+1];
  logic          pos_q [DS+1];
  logic          okd_q [DS+1];

  always_comb begin
    logic signed [11:0] ek;
    logic signed [11:0] gk;
    ek       = {{8{cfg_i.gas_switch_error[3]}}, cfg_i.gas_switch_error};
    gk       = 12'sd1340 + (ek <<< 2) + ek;
    s1_g1p_d = 42'(gk[10:0]) * 42'(ensc_pkg::tab_a(s0_rng_q));
    s3_g3p_d = 58'(s2_tb_q) * 58'(s2_g1_q);
    s3_g2_d  = $signed({3'b000, s2_adc_q, 15'b0}) + $signed({2'b00, s2_g1_q})
               - 28'sd16777216;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_adc_q <= in_data_i.adc_gas;
      s0_rng_q <= in_data_i.range_sel;
      ok_q[0]  <= in_data_i.gas_flag & in_data_i.heat_stable;
    end
    for (int k = 1; k < GP - 1; k++) begin
      if (en_i[k]) begin
        ok_q[k] <= ok_q[k-1];
      end
    end
    if (en_i[1]) begin
      s1_g1p_q <= s1_g1p_d;
      s1_tb_q  <= ensc_pkg::tab_b(s0_rng_q);
      s1_adc_q <= s0_adc_q;
    end
    if (en_i[2]) begin
      s2_g1_q  <= s1_g1p_q[41:16];
      s2_tb_q  <= s1_tb_q;
      s2_adc_q <= s1_adc_q;
    end
    if (en_i[3]) begin
      s3_g3p_q <= s3_g3p_d;
      s3_g2_q  <= s3_g2_d;
    end
    if (en_i[GP-1]) begin
      num_q[0] <= NW'(s3_g3p_q[57:9]) + NW'(s3_g2_q[27:1]);
      den_q[0] <= s3_g2_q[DW-1:0];
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      pos_q[0] <= !s3_g2_q[27] && (s3_g2_q != '0);
      okd_q[0] <= ok_q[GP-2];
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [DW-1:0] rem_d;
    logic [31:0]   quo_d;

    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [31:0]   qv;
      r  = rem_q[j];
      qv = quo_q[j];
      for (int b = 0; b < 2; b++) begin
        t = {r, num_q[j][NW-1-2*j-b]};
        if (t >= {1'b0, den_q[j]}) begin
          t  = t - {1'b0, den_q[j]};
          qv = {qv[30:0], 1'b1};
        end else begin
          qv = {qv[30:0], 1'b0};
        end
        r = t[DW-1:0];
      end
      rem_d = r;
      quo_d = qv;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[GP+j]) begin
        num_q[j+1] <= num_q[j];
        den_q[j+1] <= den_q[j];
        rem_q[j+1] <= rem_d;
        quo_q[j+1] <= quo_d;
        pos_q[j+1] <= pos_q[j];
        okd_q[j+1] <= okd_q[j];
      end
    end
  end

  assign gas_ohm_o = pos_q[DS] ? quo_q[DS] : '0;
  assign gas_ok_o  = okd_q[DS];

endmodule

// File: sv/env_sensor_compensation_top.sv
// top level: configuration registers, pipeline flow control and the two datapaths
//
//  port group      dir  handshake                 payload
//  in_*            in   in_valid_i / in_ready_o   in_data_i  (ensc_pkg::in_t)
//  out_*           out  out_valid_o / out_ready_i out_data_o (ensc_pkg::out_t)
//  cfg_*           in   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
//  one request per cycle in while in_ready_o is high; an accepted request reaches out_valid_o
//  after passing 5 gas setup stages and the 25-stage radix-4 divider
//  reset clears the stage valid bits and the calibration registers
//  each stage holds while the next one is full and stalled; empty stages fill
//  so a request is taken while a result waits unless every stage is full
module env_sensor_compensation_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ensc_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ensc_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [ensc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ensc_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int N = ensc_pkg::NSTG;

  ensc_pkg::cfg_t cfg_q;
  logic [N-1:0]   v_q, v_d;
  logic [N-1:0]   en;
  logic [16:0]    temp;
  logic [16:0]    hum;
  logic [31:0]    gas_ohm;
  logic           gas_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ensc_pkg::REG_TEMP_BASE:  cfg_q.temp_base        <= cfg_wdata_i[15:0];
        ensc_pkg::REG_TEMP_GAIN:  cfg_q.temp_gain        <= cfg_wdata_i[15:0];
        ensc_pkg::REG_TEMP_CURVE: cfg_q.temp_curve       <= cfg_wdata_i[7:0];
        ensc_pkg::REG_HUM_OFFSET: cfg_q.hum_offset       <= cfg_wdata_i[11:0];
        ensc_pkg::REG_HUM_GAIN:   cfg_q.hum_gain         <= cfg_wdata_i[11:0];
        ensc_pkg::REG_HUM_COEFFS: cfg_q.hum_coeffs       <= cfg_wdata_i[39:0];
        ensc_pkg::REG_GAS_ERR:    cfg_q.gas_switch_error <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[N-1] = !v_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < N; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  ensc_thpath u_thpath (
    .clk_i     (clk_i),
    .en_i      (en),
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .temp_o    (temp),
    .hum_o     (hum)
  );

  ensc_gaspath u_gaspath (
    .clk_i     (clk_i),
    .en_i      (en),
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .gas_ohm_o (gas_ohm),
    .gas_ok_o  (gas_ok)
  );

  assign in_ready_o                   = en[0];
  assign out_valid_o                  = v_q[N-1];
  assign out_data_o.temperature_centi = temp;
  assign out_data_o.humidity_milli    = hum;
  assign out_data_o.gas_ohm           = gas_ohm;
  assign out_data_o.gas_ok            = gas_ok;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted request did not enter the first stage");

  a_drain_frees_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output is draining");

  a_full_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !out_ready_i |-> !in_ready_o)
    else $error("request taken while every stage is full and stalled");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("waiting result dropped or changed while output stalled");

endmodule
